@@ src/dgmm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgmm_pkg: shared types and constants for the GMM classifier
// Payload structs, item kinds, register indexes and size defaults.
// ----------------------------------------------------------------------------
package dgmm_pkg;

    localparam int DEF_MAX_COMPONENTS = 16;
    localparam int DEF_MAX_FEATURES   = 16;
    localparam int DEF_SAMPLE_BITS    = 16;
    localparam int DEF_ACC_BITS       = 48;
    localparam int CFG_IDX_BITS       = 1;
    localparam int CFG_DATA_BITS      = 5;

    typedef enum logic [1:0] {
        KIND_LOAD_MEAN = 2'd0,
        KIND_LOAD_BIAS = 2'd1,
        KIND_SAMPLE    = 2'd2,
        KIND_RSVD      = 2'd3
    } t_kind;

    localparam logic [CFG_IDX_BITS-1:0] REG_COMPONENTS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FEATURES   = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         comp_sel;
        logic [3:0]         feat_sel;
        logic signed [15:0] mean_val;
        logic [15:0]        precision_val;
        logic signed [31:0] bias_val;
        logic               present;
        logic signed [DEF_SAMPLE_BITS-1:0] sample_val;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         label;
        logic signed [47:0] best_score;
        logic               none_present;
    } t_out_item;

endpackage

@@ src/diagonal_gmm_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diagonal_gmm_classifier: diagonal-covariance GMM classifier
// Operation: load items are written on acceptance; a sample item runs the
//   RD, SQ, MUL, ACC steps once per component (K components), and the last
//   feature of a vector adds an argmax pass before the result shows.
// Throughput: one item at a time, next accepted once the block is back in
//   idle and the post-reset accumulator clear is done; rate set by the shared
//   term/accumulate path walking the mean/precision memories one component per
//   step. A waiting result only holds the next emit.
// Reset: synchronous active low; clears present flags, accumulators (one pass
//   over all MAX_COMPONENTS entries after reset), feature position and state; sizes reset to 1.
// ----------------------------------------------------------------------------
module diagonal_gmm_classifier #(
    parameter int MAX_COMPONENTS = dgmm_pkg::DEF_MAX_COMPONENTS,
    parameter int MAX_FEATURES   = dgmm_pkg::DEF_MAX_FEATURES,
    parameter int ACC_BITS       = dgmm_pkg::DEF_ACC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dgmm_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dgmm_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dgmm_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [dgmm_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import dgmm_pkg::*;

    localparam int CB = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int FB = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int AB = CB + FB;
    localparam int SB = DEF_SAMPLE_BITS;
    localparam int DB = SB + 2;
    localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam int WB = ACC_BITS + 2;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RD    = 7'b0000010,
        ST_SQ    = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_ACC   = 7'b0010000,
        ST_ARG   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } t_state;

    logic signed [15:0] mean_mem [MAX_COMPONENTS*MAX_FEATURES];
    logic [15:0]        prec_mem [MAX_COMPONENTS*MAX_FEATURES];
    logic signed [31:0] bias_mem [MAX_COMPONENTS];
    logic [ACC_BITS-1:0] acc_mem [MAX_COMPONENTS];
    logic [MAX_COMPONENTS-1:0] r_present;

    t_state r_state;
    logic [4:0] r_ncomp, r_nfeat;
    logic [5:0] r_fpos;
    logic [CB:0] r_k;
    logic [CB:0] r_clr;
    logic signed [SB-1:0] r_x;
    logic signed [15:0] r_mu;
    logic [15:0] r_prec;
    logic [ACC_BITS-1:0] r_acc;
    logic [2*DB-1:0] r_d2;
    logic [ACC_BITS-1:0] r_term;
    logic signed [WB-1:0] r_best;
    logic [3:0] r_label;
    logic r_found;
    logic r_last;
    logic r_out_valid;
    t_out_item r_out;

    logic [CB:0] kuse;
    logic [5:0]  fuse;
    always_comb begin
        kuse = (r_ncomp == 5'd0) ? (CB+1)'(1)
             : ({1'b0, r_ncomp} > 6'(MAX_COMPONENTS)) ? (CB+1)'(MAX_COMPONENTS)
             : (CB+1)'(r_ncomp);
        fuse = (r_nfeat == 5'd0) ? 6'd1
             : ({1'b0, r_nfeat} > 6'(MAX_FEATURES)) ? 6'(MAX_FEATURES)
             : {1'b0, r_nfeat};
    end

    logic emit_go;
    assign emit_go = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);

    assign o_in_ready  = (r_state == ST_IDLE) && (r_clr == '0);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    logic in_fire;
    assign in_fire = i_in_valid && o_in_ready;

    logic [AB-1:0] rd_addr;
    assign rd_addr = {r_k[CB-1:0], r_fpos[FB-1:0]};

    // term: floor(d2*prec/256) saturated == floor(d2*prec)>>8 saturated
    logic [2*DB+15:0] prod;
    logic [2*DB+7:0]  prod_sh;
    logic [ACC_BITS-1:0] term_sat;
    logic [ACC_BITS:0] sum;
    assign prod    = r_d2 * r_prec;
    assign prod_sh = prod[2*DB+15:8];
    always_comb begin
        if (WB'(prod_sh) >= WB'(ACC_MAX)) term_sat = ACC_MAX;
        else term_sat = ACC_BITS'(prod_sh);
    end
    assign sum = {1'b0, r_acc} + {1'b0, r_term};

    logic signed [DB-1:0] diff;
    logic [DB-1:0] adiff;
    assign diff  = DB'(r_x) - DB'(r_mu);
    assign adiff = diff[DB-1] ? DB'(-diff) : DB'(diff);

    // score of component r_k-1, whose acc was read last cycle
    logic signed [WB-1:0] sc_prev;
    assign sc_prev = WB'(bias_mem[CB'(r_k - 1'b1)]) - WB'(({2'b0, r_acc} + 1) >> 1);

    // memory ports
    always_ff @(posedge i_clk) begin
        if (in_fire && i_in_data.kind == KIND_LOAD_MEAN
            && 32'(i_in_data.comp_sel) < MAX_COMPONENTS
            && 32'(i_in_data.feat_sel) < MAX_FEATURES) begin
            mean_mem[{CB'(i_in_data.comp_sel), FB'(i_in_data.feat_sel)}] <= i_in_data.mean_val;
            prec_mem[{CB'(i_in_data.comp_sel), FB'(i_in_data.feat_sel)}] <=
                i_in_data.precision_val;
        end
        if (in_fire && i_in_data.kind == KIND_LOAD_BIAS
            && 32'(i_in_data.comp_sel) < MAX_COMPONENTS)
            bias_mem[CB'(i_in_data.comp_sel)] <= i_in_data.bias_val;
        r_mu   <= mean_mem[rd_addr];
        r_prec <= prec_mem[rd_addr];
        r_acc  <= acc_mem[r_k[CB-1:0]];
        if (r_clr != '0)
            acc_mem[CB'(r_clr - 1'b1)] <= '0;
        else if (r_state == ST_ACC)
            acc_mem[r_k[CB-1:0]] <= (sum >= {1'b0, ACC_MAX}) ? ACC_MAX : sum[ACC_BITS-1:0];
        else if (r_state == ST_ARG && r_k < (CB+1)'(MAX_COMPONENTS))
            acc_mem[r_k[CB-1:0]] <= '0;
        r_d2   <= adiff * adiff;
        r_term <= term_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ncomp     <= 5'd1;
            r_nfeat     <= 5'd1;
            r_fpos      <= '0;
            r_k         <= '0;
            r_clr       <= (CB+1)'(MAX_COMPONENTS);
            r_present   <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_COMPONENTS) r_ncomp <= i_cfg_data;
                if (i_cfg_index == REG_FEATURES)   r_nfeat <= i_cfg_data;
            end
            if (r_clr != '0) r_clr <= r_clr - 1'b1;
            if (emit_go) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (i_in_data.kind == KIND_LOAD_BIAS
                            && 32'(i_in_data.comp_sel) < MAX_COMPONENTS)
                            r_present[CB'(i_in_data.comp_sel)] <= i_in_data.present;
                        if (i_in_data.kind == KIND_SAMPLE) begin
                            r_x    <= i_in_data.sample_val;
                            r_k    <= '0;
                            r_last <= (r_fpos + 6'd1 >= fuse);
                            r_state <= (32'(r_fpos) < MAX_FEATURES) ? ST_RD : ST_ARG;
                            r_found <= 1'b0;
                        end
                    end
                end
                ST_RD:  r_state <= ST_SQ;
                ST_SQ:  r_state <= ST_MUL;
                ST_MUL: r_state <= ST_ACC;
                ST_ACC: begin
                    if (r_k + 1'b1 < kuse) begin
                        r_k <= r_k + 1'b1;
                        r_state <= ST_RD;
                    end else begin
                        r_k <= '0;
                        if (r_last) begin
                            r_state <= ST_ARG;
                        end else begin
                            r_fpos <= r_fpos + 6'd1;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_ARG: begin
                    // r_acc holds the acc read at the previous cycle's r_k, i.e. of component r_k-1
                    if (r_k != '0 && r_k <= kuse && r_present[CB'(r_k - 1'b1)]) begin
                        if (!r_found || sc_prev > r_best) begin
                            r_best  <= sc_prev;
                            r_label <= 4'(r_k - 1'b1);
                            r_found <= 1'b1;
                        end
                    end
                    if (r_k < (CB+1)'(MAX_COMPONENTS)) r_k <= r_k + 1'b1;
                    else r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        r_out.label <= r_found ? r_label : 4'd0;
                        r_out.none_present <= !r_found;
                        r_out.best_score <= !r_found ? 48'sd0
                            : (r_best > WB'(48'sh7FFFFFFFFFFF)) ? 48'sh7FFFFFFFFFFF
                            : (r_best < -WB'(49'sh800000000000)) ? 48'sh800000000000
                            : r_best[47:0];
                        r_fpos  <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ src/dgmm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgmm_checker: port-level checks for the GMM classifier
// Watches the result handshake and result fields over time.
// ----------------------------------------------------------------------------
module dgmm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input dgmm_pkg::t_out_item o_out_data
);
    import dgmm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped while stalled");

    a_none_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.none_present |-> o_out_data.label == 4'd0)
        else $error("none_present with nonzero label");

    a_none_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.none_present |-> o_out_data.best_score == '0)
        else $error("none_present with nonzero score");

endmodule

bind diagonal_gmm_classifier dgmm_checker u_dgmm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
);

@@ verif/diagonal_gmm_classifier_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diagonal_gmm_classifier_tb: self-checking bench for the GMM classifier
// A directed table walks reset values, extreme operands, ties and the empty
// mixture. Random load/sample traffic follows over several register settings.
// Every result is checked field by field against an in-bench scoring model or,
// for some directed rows, a fixed expected value. Both handshakes are throttled
// at random and the receiver stalls for a long stretch at least once.
// ----------------------------------------------------------------------------
module diagonal_gmm_classifier_tb;
    import dgmm_pkg::*;

    localparam int NCOMP = DEF_MAX_COMPONENTS;
    localparam int NFEAT = DEF_MAX_FEATURES;
    localparam longint unsigned ACC_SAT = (64'd1 << (DEF_ACC_BITS - 1)) - 1;
    localparam longint SCORE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SCORE_MIN = -64'sh0000_8000_0000_0000;
    localparam int DRAIN_CYCLES = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = REG_COMPONENTS;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    diagonal_gmm_classifier DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scoring model state
    longint          mu_tab [NCOMP*NFEAT];
    longint unsigned prec_tab [NCOMP*NFEAT];
    bit              loaded [NCOMP*NFEAT];
    longint          bias_tab [NCOMP];
    bit              active [NCOMP];
    longint unsigned dist_acc [NCOMP];
    int              feat_idx;
    logic [4:0]      comps_reg;
    logic [4:0]      feats_reg;

    t_out_item pending_results[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        recv_hold = 0;

    task automatic report(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int eff_count(input logic [4:0] v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic longint unsigned acc_add(input longint unsigned a,
                                                input longint unsigned b);
        if (a >= ACC_SAT || b >= ACC_SAT - a) return ACC_SAT;
        return a + b;
    endfunction

    function automatic longint unsigned sq_term(input longint x, input longint mu,
                                                input longint unsigned p);
        longint          d;
        longint unsigned ad;
        longint unsigned d2;
        d  = x - mu;
        ad = (d < 0) ? longint'(-d) : longint'(d);
        d2 = ad * ad;
        if (p != 0 && (d2 >> 8) > ACC_SAT / p) return ACC_SAT;
        return acc_add((d2 >> 8) * p, ((d2 & 255) * p) >> 8);
    endfunction

    // applies one accepted transaction; returns 1 with the result when a vector closes
    function automatic bit classify_step(input t_in_item it, output t_out_item res);
        int     ncomp;
        int     nfeat;
        int     idx;
        longint x;
        longint s;
        longint best;
        bit     found;
        res   = '0;
        ncomp = eff_count(comps_reg, NCOMP);
        nfeat = eff_count(feats_reg, NFEAT);
        best  = 0;
        found = 0;
        case (t_kind'(it.kind))
            KIND_LOAD_MEAN: begin
                idx = it.comp_sel * NFEAT + it.feat_sel;
                mu_tab[idx]   = longint'(it.mean_val);
                prec_tab[idx] = it.precision_val;
                loaded[idx]   = 1;
                return 0;
            end
            KIND_LOAD_BIAS: begin
                bias_tab[it.comp_sel] = longint'(it.bias_val);
                active[it.comp_sel]   = it.present;
                return 0;
            end
            KIND_SAMPLE: begin
                x = longint'(it.sample_val);
                for (int k = 0; k < ncomp; k++) begin
                    idx = k * NFEAT + feat_idx;
                    dist_acc[k] = acc_add(dist_acc[k],
                                          sq_term(x, mu_tab[idx], prec_tab[idx]));
                end
                if (feat_idx + 1 < nfeat) begin
                    feat_idx++;
                    return 0;
                end
                for (int k = 0; k < ncomp; k++) begin
                    if (active[k]) begin
                        s = bias_tab[k] - longint'((dist_acc[k] + 1) >> 1);
                        if (!found || s > best) begin
                            best = s;
                            res.label = 4'(k);
                            found = 1;
                        end
                    end
                end
                if (best > SCORE_MAX) best = SCORE_MAX;
                if (best < SCORE_MIN) best = SCORE_MIN;
                res.best_score   = found ? best[47:0] : '0;
                res.none_present = !found;
                for (int k = 0; k < NCOMP; k++) dist_acc[k] = 0;
                feat_idx = 0;
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    task automatic send_item(input t_in_item it, input bit fixed, input t_out_item fixed_res);
        t_out_item res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (classify_step(it, res)) pending_results.push_back(fixed ? fixed_res : res);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [4:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_COMPONENTS) comps_reg = val;
        else feats_reg = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_shape(input logic [4:0] nc, input logic [4:0] nf);
        wait_idle();
        write_reg(REG_COMPONENTS, nc);
        write_reg(REG_FEATURES, nf);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // random transaction; a sample whose table entries are missing becomes a load of the lowest missing one
    function automatic t_in_item rand_item();
        t_in_item it;
        int       r;
        int       ncomp;
        it = $bits(t_in_item)'({$urandom, $urandom, $urandom});
        it.mean_val      = pick16();
        it.precision_val = ($urandom_range(3) == 0) ? pick16() : 16'($urandom_range(1023));
        it.sample_val    = pick16();
        it.bias_val      = ($urandom_range(3) == 0) ? {$urandom} : $signed($urandom_range(65535)) - 32768;
        it.present       = ($urandom_range(9) < 7);
        r = $urandom_range(99);
        if (r < 4) it.kind = KIND_RSVD;
        else if (r < 16) it.kind = KIND_LOAD_MEAN;
        else if (r < 28) it.kind = KIND_LOAD_BIAS;
        else it.kind = KIND_SAMPLE;
        if (it.kind == KIND_SAMPLE) begin
            ncomp = eff_count(comps_reg, NCOMP);
            for (int k = ncomp - 1; k >= 0; k--) begin
                if (!loaded[k * NFEAT + feat_idx]) begin
                    it.kind     = KIND_LOAD_MEAN;
                    it.comp_sel = 4'(k);
                    it.feat_sel = 4'(feat_idx);
                end
            end
        end
        return it;
    endfunction

    typedef struct {
        bit         is_cfg;
        logic [4:0] nc;
        logic [4:0] nf;
        t_in_item   it;
        bit         fixed;
        t_out_item  res;
    } t_row;

    function automatic t_row mk(input t_kind kd, input int c, input int f,
                                input logic [15:0] mu, input logic [15:0] p,
                                input logic [31:0] b, input bit pr, input logic [15:0] x);
        t_row row;
        row = '{default: '0};
        row.it.kind = kd;
        row.it.comp_sel = 4'(c);
        row.it.feat_sel = 4'(f);
        row.it.mean_val = mu;
        row.it.precision_val = p;
        row.it.bias_val = b;
        row.it.present = pr;
        row.it.sample_val = x;
        return row;
    endfunction

    function automatic t_row fx(input t_row row, input int lbl, input logic [47:0] sc,
                                input bit np);
        row.fixed = 1;
        row.res   = '{label: 4'(lbl), best_score: sc, none_present: np};
        return row;
    endfunction

    function automatic t_row cfg_row(input logic [4:0] nc, input logic [4:0] nf);
        t_row row;
        row = '{default: '0};
        row.is_cfg = 1;
        row.nc = nc;
        row.nf = nf;
        return row;
    endfunction

    // receiver side
    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report("result with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.label !== want.label)
                    report($sformatf("label %0d want %0d", o_out_data.label, want.label));
                if (o_out_data.best_score !== want.best_score)
                    report($sformatf("best_score %0d want %0d",
                                     o_out_data.best_score, want.best_score));
                if (o_out_data.none_present !== want.none_present)
                    report($sformatf("none_present %0b want %0b",
                                     o_out_data.none_present, want.none_present));
            end
        end
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_row dir[$];
        t_in_item it;
        for (int i = 0; i < NCOMP*NFEAT; i++) begin
            mu_tab[i] = 0; prec_tab[i] = 0; loaded[i] = 0;
        end
        for (int k = 0; k < NCOMP; k++) begin
            bias_tab[k] = 0; active[k] = 0; dist_acc[k] = 0;
        end
        feat_idx = 0;
        comps_reg = 5'd1;
        feats_reg = 5'd1;

        dir.push_back(mk(KIND_LOAD_MEAN, 0, 0, 16'h8000, 16'hFFFF, 0, 0, 0));
        dir.push_back(fx(mk(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 16'h7FFF), 0, 48'd0, 1));
        dir.push_back(mk(KIND_LOAD_BIAS, 0, 0, 0, 0, 32'h8000_0000, 1, 0));
        dir.push_back(mk(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 16'h7FFF));
        dir.push_back(mk(KIND_LOAD_BIAS, 0, 0, 0, 0, 32'h7FFF_FFFF, 1, 0));
        dir.push_back(mk(KIND_LOAD_MEAN, 0, 0, 16'h0000, 16'h0000, 0, 0, 0));
        dir.push_back(fx(mk(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 16'h8000), 0, 48'h7FFF_FFFF, 0));
        dir.push_back(mk(KIND_RSVD, 15, 15, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 16'hFFFF));
        dir.push_back(mk(KIND_LOAD_BIAS, 0, 0, 0, 0, 32'h1234_5678, 0, 0));
        dir.push_back(fx(mk(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 16'h8000), 0, 48'd0, 1));
        dir.push_back(cfg_row(5'd2, 5'd2));
        dir.push_back(mk(KIND_LOAD_MEAN, 1, 0, 16'h0000, 16'h0000, 0, 0, 0));
        dir.push_back(mk(KIND_LOAD_MEAN, 0, 1, 16'h0000, 16'h0000, 0, 0, 0));
        dir.push_back(mk(KIND_LOAD_MEAN, 1, 1, 16'h0000, 16'h0000, 0, 0, 0));
        dir.push_back(mk(KIND_LOAD_BIAS, 0, 0, 0, 0, 32'd100, 1, 0));
        dir.push_back(mk(KIND_LOAD_BIAS, 1, 0, 0, 0, 32'd100, 1, 0));
        dir.push_back(mk(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 16'h1234));
        dir.push_back(fx(mk(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 16'hFEDC), 0, 48'd100, 0));
        dir.push_back(mk(KIND_LOAD_BIAS, 1, 0, 0, 0, 32'd200, 1, 0));
        dir.push_back(mk(KIND_LOAD_MEAN, 1, 1, 16'h0100, 16'h0200, 0, 0, 0));
        dir.push_back(mk(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 16'h0000));
        dir.push_back(mk(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 16'h0300));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir[i]) begin
            if (dir[i].is_cfg) set_shape(dir[i].nc, dir[i].nf);
            else send_item(dir[i].it, dir[i].fixed, dir[i].res);
        end

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_shape(5'd16, 5'd16);
                1: set_shape(5'd0, 5'd0);
                2: set_shape(5'd31, 5'd31);
                3: set_shape(5'd16, 5'd1);
                4: set_shape(5'd1, 5'd16);
                5: set_shape(5'd3, 5'd4);
                default: set_shape(5'($urandom_range(31)), 5'($urandom_range(5)));
            endcase
            if (ph < 4) begin
                send_idle_pct = 28; recv_idle_pct = 50;
            end else if (ph < 7) begin
                send_idle_pct = 50; recv_idle_pct = 28;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            for (int n = 0; n < 120; n++) begin
                if (ph == 3 && n == 10) recv_hold = 600;
                if (ph == 5 && n == 60) begin
                    i_in_valid <= 1'b0;
                    while (pending_results.size() != 0) @(posedge i_clk);
                    @(negedge i_clk);
                end
                it = rand_item();
                send_item(it, 0, '0);
            end
        end

        wait_idle();
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
src/dgmm_pkg.sv
src/diagonal_gmm_classifier.sv
src/dgmm_checker.sv
verif/diagonal_gmm_classifier_tb.sv
